@@ hw/rtl/movdec_pkg.sv @@
`default_nettype none

package movdec_pkg;

  // Six consecutive instruction bytes, byte 0 is the opcode.
  localparam int unsigned WindowBytes = 6;
  typedef logic [WindowBytes-1:0][7:0] window_t;

  // Form numbers as reported on the result.
  typedef enum logic [2:0] {
    FORM_RM_REG  = 3'd0,
    FORM_IMM_RM  = 3'd1,
    FORM_IMM_REG = 3'd2,
    FORM_MEM_ACC = 3'd3,
    FORM_ACC_MEM = 3'd4
  } form_e;

  // Opcode patterns and the masks they are compared under.
  localparam logic [7:0] OpRmRegPat  = 8'b1000_1000;
  localparam logic [7:0] OpRmRegMask = 8'b1111_1100;
  localparam logic [7:0] OpImmRmPat  = 8'b1100_0110;
  localparam logic [7:0] OpImmRegPat = 8'b1011_0000;
  localparam logic [7:0] OpImmRegMsk = 8'b1111_0000;
  localparam logic [7:0] OpMemAccPat = 8'b1010_0000;
  localparam logic [7:0] OpAccMemPat = 8'b1010_0010;
  localparam logic [7:0] OpWMask     = 8'b1111_1110;

  // ModR/M field masks.
  localparam logic [7:0] ModrmModMask = 8'b1100_0000;
  localparam logic [7:0] ModrmRegMask = 8'b0011_1000;
  localparam logic [7:0] OpImmRegWBit = 8'b0000_1000;

  // Values of the mod field.
  localparam logic [1:0] ModNoDisp = 2'b00;
  localparam logic [1:0] ModDisp8  = 2'b01;
  localparam logic [1:0] ModDisp16 = 2'b10;
  localparam logic [1:0] ModReg    = 2'b11;

  // rm code that selects a direct address when mod is 00.
  localparam logic [2:0] RmDirect = 3'b110;

  // Everything one decoded instruction produces.
  typedef struct packed {
    logic        recognized;
    form_e       form;
    logic        wide;
    logic        dest_is_reg;
    logic [3:0]  reg_index;
    logic        rm_is_memory;
    logic [3:0]  rm_code;
    logic        direct_address;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  instr_length;
  } decode_t;

endpackage

`default_nettype wire

@@ hw/rtl/movdec_decode.sv @@
`default_nettype none

// Combinational decode of one registered instruction window.
module movdec_decode (
  input  var movdec_pkg::window_t win_i,
  output var movdec_pkg::decode_t dec_o
);

  logic [7:0] op;
  logic [1:0] modf;
  logic [2:0] regf;
  logic [2:0] rmf;
  logic [1:0] dlen;
  logic [15:0] disp;
  logic       mem;
  logic       direct;
  logic [3:0] rmc;
  logic [15:0] imm_rm;

  assign op   = win_i[0];
  assign modf = win_i[1][7:6];
  assign regf = win_i[1][5:3];
  assign rmf  = win_i[1][2:0];

  // ModR/M operand and displacement, shared by the first two forms.
  always_comb begin
    mem    = 1'b1;
    direct = 1'b0;
    dlen   = 2'd0;
    disp   = '0;
    rmc    = {1'b0, rmf};
    case (modf)
      movdec_pkg::ModReg: begin
        mem = 1'b0;
        rmc = {op[0], rmf};
      end
      movdec_pkg::ModNoDisp: begin
        if (rmf == movdec_pkg::RmDirect) begin
          direct = 1'b1;
          dlen   = 2'd2;
          disp   = {win_i[3], win_i[2]};
        end
      end
      movdec_pkg::ModDisp8: begin
        dlen = 2'd1;
        disp = {{8{win_i[2][7]}}, win_i[2]};
      end
      movdec_pkg::ModDisp16: begin
        dlen = 2'd2;
        disp = {win_i[3], win_i[2]};
      end
      default: begin
        mem = 1'b0;
      end
    endcase
  end

  // Immediate data of the immediate-to-reg/mem form follows the displacement.
  always_comb begin
    case (dlen)
      2'd0:    imm_rm = {win_i[3], win_i[2]};
      2'd1:    imm_rm = {win_i[4], win_i[3]};
      default: imm_rm = {win_i[5], win_i[4]};
    endcase
    if (!op[0]) begin
      imm_rm[15:8] = 8'h00;
    end
  end

  always_comb begin
    dec_o              = '0;
    dec_o.form         = movdec_pkg::FORM_RM_REG;
    dec_o.instr_length = 3'd1;
    if ((op & movdec_pkg::OpRmRegMask) == movdec_pkg::OpRmRegPat) begin
      dec_o.recognized     = 1'b1;
      dec_o.form           = movdec_pkg::FORM_RM_REG;
      dec_o.wide           = op[0];
      dec_o.dest_is_reg    = op[1];
      dec_o.reg_index      = {op[0], regf};
      dec_o.rm_is_memory   = mem;
      dec_o.rm_code        = rmc;
      dec_o.direct_address = direct;
      dec_o.displacement   = disp;
      dec_o.instr_length   = 3'd2 + {1'b0, dlen};
    end else if ((op & movdec_pkg::OpWMask) == movdec_pkg::OpImmRmPat) begin
      dec_o.recognized     = 1'b1;
      dec_o.form           = movdec_pkg::FORM_IMM_RM;
      dec_o.wide           = op[0];
      dec_o.rm_is_memory   = mem;
      dec_o.rm_code        = rmc;
      dec_o.direct_address = direct;
      dec_o.displacement   = disp;
      dec_o.immediate      = imm_rm;
      dec_o.instr_length   = 3'd3 + {1'b0, dlen} + {2'b00, op[0]};
    end else if ((op & movdec_pkg::OpImmRegMsk) == movdec_pkg::OpImmRegPat) begin
      dec_o.recognized   = 1'b1;
      dec_o.form         = movdec_pkg::FORM_IMM_REG;
      dec_o.wide         = op[3];
      dec_o.dest_is_reg  = 1'b1;
      dec_o.reg_index    = {op[3], op[2:0]};
      dec_o.immediate    = {(op[3] ? win_i[2] : 8'h00), win_i[1]};
      dec_o.instr_length = 3'd2 + {2'b00, op[3]};
    end else if ((op & movdec_pkg::OpWMask) == movdec_pkg::OpMemAccPat ||
                 (op & movdec_pkg::OpWMask) == movdec_pkg::OpAccMemPat) begin
      dec_o.recognized   = 1'b1;
      dec_o.form         = op[1] ? movdec_pkg::FORM_ACC_MEM : movdec_pkg::FORM_MEM_ACC;
      dec_o.wide         = op[0];
      dec_o.dest_is_reg  = ~op[1];
      dec_o.reg_index    = {op[0], 3'b000};
      dec_o.immediate    = {win_i[2], win_i[1]};
      dec_o.instr_length = 3'd3;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mov_instruction_decoder.sv @@
`default_nettype none

// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+------------------------------------------
// command   | in        | start_i / busy_o  | opcode_byte_i .. sixth_byte_i
// result    | out       | valid_o (strobe)  | recognized_o .. instr_length_o
//
// One instruction window is taken in every cycle; busy_o is never raised.
// A result is shown in the cycle after the one its window spends in the input register,
// for a single cycle. The throughput of one window per cycle is set by the single decode
// stage between the two registers. rst_ni clears both valid flags asynchronously; payload
// registers are not reset. The receiver cannot stall, so no result is ever held.
module mov_instruction_decoder (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               start_i,
  output var logic               busy_o,
  input  var logic [7:0]         opcode_byte_i,
  input  var logic [7:0]         second_byte_i,
  input  var logic [7:0]         third_byte_i,
  input  var logic [7:0]         fourth_byte_i,
  input  var logic [7:0]         fifth_byte_i,
  input  var logic [7:0]         sixth_byte_i,
  output var logic               valid_o,
  output var logic               recognized_o,
  output var logic [2:0]         form_o,
  output var logic               wide_o,
  output var logic               dest_is_reg_o,
  output var logic [3:0]         reg_index_o,
  output var logic               rm_is_memory_o,
  output var logic [3:0]         rm_code_o,
  output var logic               direct_address_o,
  output var logic signed [15:0] displacement_o,
  output var logic [15:0]        immediate_o,
  output var logic [2:0]         instr_length_o
);

  logic                in_valid_q;
  movdec_pkg::window_t win_q;
  movdec_pkg::window_t win_d;
  movdec_pkg::decode_t dec;
  logic                out_valid_q;
  movdec_pkg::decode_t res_q;

  // The decoder never holds a command off: every cycle may carry a new transfer.
  assign busy_o = 1'b0;

  assign win_d = {sixth_byte_i, fifth_byte_i, fourth_byte_i,
                  third_byte_i, second_byte_i, opcode_byte_i};

  // Input register: captures the window on each command transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      win_q <= win_d;
    end
  end

  movdec_decode u_decode (
    .win_i (win_q),
    .dec_o (dec)
  );

  // Result register: the decoded fields of the window held in the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= dec;
    end
  end

  assign valid_o          = out_valid_q;
  assign recognized_o     = res_q.recognized;
  assign form_o           = res_q.form;
  assign wide_o           = res_q.wide;
  assign dest_is_reg_o    = res_q.dest_is_reg;
  assign reg_index_o      = res_q.reg_index;
  assign rm_is_memory_o   = res_q.rm_is_memory;
  assign rm_code_o        = res_q.rm_code;
  assign direct_address_o = res_q.direct_address;
  assign displacement_o   = res_q.displacement;
  assign immediate_o      = res_q.immediate;
  assign instr_length_o   = res_q.instr_length;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for the MOV instruction decoder.
//
// The decoder takes one six-byte instruction window per command transfer and returns one
// decoded result, from its result register, as a single-cycle strobe on valid_o. The receiving side
// cannot hold results off, so only the sending side is throttled here.
//
// Every accepted window is run through a predictor in this file. The prediction is queued,
// and each strobed result is compared field by field with the oldest queued prediction.
module testbench;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned ReportLimit = 10;
  // The block is two registers deep; spare cycles at the end catch stray results.
  localparam int unsigned DrainCycles = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [7:0]  opcode_byte_i = '0;
  logic [7:0]  second_byte_i = '0;
  logic [7:0]  third_byte_i = '0;
  logic [7:0]  fourth_byte_i = '0;
  logic [7:0]  fifth_byte_i = '0;
  logic [7:0]  sixth_byte_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic        recognized_o;
  logic [2:0]  form_o;
  logic        wide_o;
  logic        dest_is_reg_o;
  logic [3:0]  reg_index_o;
  logic        rm_is_memory_o;
  logic [3:0]  rm_code_o;
  logic        direct_address_o;
  logic signed [15:0] displacement_o;
  logic [15:0] immediate_o;
  logic [2:0]  instr_length_o;

  // Predicted decodes, oldest at the front.
  movdec_pkg::decode_t expected_decodes[$];

  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned windows_sent = 0;
  int unsigned results_checked = 0;
  int unsigned unrecognised_tally = 0;
  int unsigned form_tally[5] = '{default: 0};

  always #2 clk_i = ~clk_i;

  mov_instruction_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_byte_i    (opcode_byte_i),
    .second_byte_i    (second_byte_i),
    .third_byte_i     (third_byte_i),
    .fourth_byte_i    (fourth_byte_i),
    .fifth_byte_i     (fifth_byte_i),
    .sixth_byte_i     (sixth_byte_i),
    .valid_o          (valid_o),
    .recognized_o     (recognized_o),
    .form_o           (form_o),
    .wide_o           (wide_o),
    .dest_is_reg_o    (dest_is_reg_o),
    .reg_index_o      (reg_index_o),
    .rm_is_memory_o   (rm_is_memory_o),
    .rm_code_o        (rm_code_o),
    .direct_address_o (direct_address_o),
    .displacement_o   (displacement_o),
    .immediate_o      (immediate_o),
    .instr_length_o   (instr_length_o)
  );

  // Decodes one window the way the block is meant to. Anything that matches none of the
  // five opcode patterns gives an all-zero result with a length of one byte.
  function automatic movdec_pkg::decode_t predict_mov(input movdec_pkg::window_t win);
    movdec_pkg::decode_t d;
    logic [7:0]  op;
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        w;
    logic [2:0]  disp_len;
    int unsigned data_pos;
    d         = '0;
    d.instr_length = 3'd1;
    op        = win[0];
    mod_field = win[1][7:6];
    reg_field = win[1][5:3];
    rm_field  = win[1][2:0];
    disp_len  = 3'd0;
    if ((op & movdec_pkg::OpRmRegMask) == movdec_pkg::OpRmRegPat ||
        (op & movdec_pkg::OpWMask) == movdec_pkg::OpImmRmPat) begin
      // Both ModR/M forms: the w bit is opcode bit 0.
      w = op[0];
      d.recognized = 1'b1;
      d.wide       = w;
      if (mod_field == movdec_pkg::ModReg) begin
        d.rm_code = {w, rm_field};
      end else begin
        d.rm_is_memory = 1'b1;
        d.rm_code      = {1'b0, rm_field};
        case (mod_field)
          movdec_pkg::ModNoDisp: begin
            // Mod 00 with rm 110 is a 16-bit direct address, not [BP].
            if (rm_field == movdec_pkg::RmDirect) begin
              d.direct_address = 1'b1;
              d.displacement   = {win[3], win[2]};
              disp_len         = 3'd2;
            end
          end
          movdec_pkg::ModDisp8: begin
            d.displacement = {{8{win[2][7]}}, win[2]};
            disp_len       = 3'd1;
          end
          default: begin
            d.displacement = {win[3], win[2]};
            disp_len       = 3'd2;
          end
        endcase
      end
      if ((op & movdec_pkg::OpRmRegMask) == movdec_pkg::OpRmRegPat) begin
        d.form         = movdec_pkg::FORM_RM_REG;
        d.dest_is_reg  = op[1];
        d.reg_index    = {w, reg_field};
        d.instr_length = 3'd2 + disp_len;
      end else begin
        // The data follows any displacement; the reg field is ignored.
        d.form         = movdec_pkg::FORM_IMM_RM;
        data_pos       = 2 + int'(disp_len);
        d.immediate    = w ? {win[data_pos + 1], win[data_pos]} : {8'h00, win[data_pos]};
        d.instr_length = 3'd3 + disp_len + {2'b00, w};
      end
    end else if ((op & movdec_pkg::OpImmRegMsk) == movdec_pkg::OpImmRegPat) begin
      // Register in the opcode, no ModR/M byte.
      w = |(op & movdec_pkg::OpImmRegWBit);
      d.recognized   = 1'b1;
      d.form         = movdec_pkg::FORM_IMM_REG;
      d.wide         = w;
      d.dest_is_reg  = 1'b1;
      d.reg_index    = {w, op[2:0]};
      d.immediate    = w ? {win[2], win[1]} : {8'h00, win[1]};
      d.instr_length = w ? 3'd3 : 3'd2;
    end else if ((op & movdec_pkg::OpWMask) == movdec_pkg::OpMemAccPat ||
                 (op & movdec_pkg::OpWMask) == movdec_pkg::OpAccMemPat) begin
      // Accumulator forms carry a 16-bit direct address, reported as the immediate.
      w = op[0];
      d.recognized   = 1'b1;
      d.form         = ((op & movdec_pkg::OpWMask) == movdec_pkg::OpMemAccPat) ?
                       movdec_pkg::FORM_MEM_ACC : movdec_pkg::FORM_ACC_MEM;
      d.wide         = w;
      d.dest_is_reg  = ((op & movdec_pkg::OpWMask) == movdec_pkg::OpMemAccPat);
      d.reg_index    = {w, 3'b000};
      d.immediate    = {win[2], win[1]};
      d.instr_length = 3'd3;
    end
    return d;
  endfunction

  function automatic string describe_decode(input movdec_pkg::decode_t d);
    return {$sformatf("rec=%0b form=%0d w=%0b d=%0b reg=%0d mem=%0b rm=%0d dir=%0b",
                      d.recognized, d.form, d.wide, d.dest_is_reg, d.reg_index,
                      d.rm_is_memory, d.rm_code, d.direct_address),
            $sformatf(" disp=%h imm=%h len=%0d", d.displacement, d.immediate,
                      d.instr_length)};
  endfunction

  // Sends one window. Before the transfer the sender may idle at random. start_i
  // stays high from one transfer to the next when there is no gap, so it is never lowered
  // and raised within the same step.
  task automatic send_window(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
    movdec_pkg::window_t win;
    movdec_pkg::decode_t predicted;
    win = {b5, b4, b3, b2, b1, op};
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    opcode_byte_i <= op;
    second_byte_i <= b1;
    third_byte_i  <= b2;
    fourth_byte_i <= b3;
    fifth_byte_i  <= b4;
    sixth_byte_i  <= b5;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    // The transfer has taken place at this edge.
    predicted = predict_mov(win);
    expected_decodes.push_back(predicted);
    windows_sent++;
    if (predicted.recognized) form_tally[predicted.form]++;
    else unrecognised_tally++;
  endtask

  // Opcodes that lie just beside the five patterns, and the two ends of the byte range.
  task automatic test_unrecognised_opcodes();
    send_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_window(8'h8C, 8'hC0, 8'h12, 8'h34, 8'h56, 8'h78);
    send_window(8'hC4, 8'h06, 8'h12, 8'h34, 8'h56, 8'h78);
    send_window(8'hC8, 8'h45, 8'h80, 8'h00, 8'h00, 8'h00);
    send_window(8'hA4, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
  endtask

  // Register or memory to or from register: every mod value, both directions, both widths.
  task automatic test_rm_reg_form();
    send_window(8'h89, 8'hC3, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_window(8'h8A, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'h8B, 8'h36, 8'h34, 8'h12, 8'h00, 8'h00);
    send_window(8'h88, 8'h45, 8'h80, 8'h00, 8'h00, 8'h00);
    send_window(8'h89, 8'h47, 8'h7F, 8'hFF, 8'h00, 8'h00);
    send_window(8'h8B, 8'hBF, 8'hFF, 8'h80, 8'h00, 8'h00);
  endtask

  // Immediate data to register or memory: the data sits after the displacement, so the
  // direct address and the 16-bit displacement give the longest instructions.
  task automatic test_immediate_forms();
    send_window(8'hC6, 8'h45, 8'hF0, 8'hAB, 8'hCD, 8'hEF);
    send_window(8'hC7, 8'h86, 8'h34, 8'h12, 8'hFF, 8'hFF);
    send_window(8'hC7, 8'h06, 8'h00, 8'h80, 8'hCD, 8'hAB);
    send_window(8'hC7, 8'hF8, 8'hFF, 8'h00, 8'h11, 8'h22);
    send_window(8'hB0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_window(8'hBF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_window(8'hB8, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Memory to accumulator and accumulator to memory, byte and word.
  task automatic test_accumulator_forms();
    send_window(8'hA0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'hA1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_window(8'hA2, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00);
    send_window(8'hA3, 8'hCD, 8'hAB, 8'h00, 8'h00, 8'h00);
  endtask

  // Mostly well-formed MOV opcodes with random operand bits and random trailing bytes; a
  // fifth of the windows carry a fully random opcode byte.
  task automatic test_random_traffic(input int unsigned windows, input int unsigned idle_pct);
    logic [7:0] op;
    logic [7:0] noise;
    sender_idle_pct = idle_pct;
    repeat (windows) begin
      noise = 8'($urandom);
      case ($urandom_range(9))
        0, 1:    op = movdec_pkg::OpRmRegPat | (noise & ~movdec_pkg::OpRmRegMask);
        2, 3:    op = movdec_pkg::OpImmRmPat | (noise & ~movdec_pkg::OpWMask);
        4, 5:    op = movdec_pkg::OpImmRegPat | (noise & ~movdec_pkg::OpImmRegMsk);
        6:       op = movdec_pkg::OpMemAccPat | (noise & ~movdec_pkg::OpWMask);
        7:       op = movdec_pkg::OpAccMemPat | (noise & ~movdec_pkg::OpWMask);
        default: op = noise;
      endcase
      send_window(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    end
  endtask

  // Result checker: every strobe is one result transfer and must match the oldest
  // prediction still waiting.
  always @(posedge clk_i) begin
    movdec_pkg::decode_t observed;
    movdec_pkg::decode_t predicted;
    string   wrong_fields;
    if (rst_ni && valid_o !== 1'b0) begin
      observed = '{recognized: recognized_o, form: movdec_pkg::form_e'(form_o),
                   wide: wide_o,
                   dest_is_reg: dest_is_reg_o, reg_index: reg_index_o,
                   rm_is_memory: rm_is_memory_o, rm_code: rm_code_o,
                   direct_address: direct_address_o, displacement: displacement_o,
                   immediate: immediate_o, instr_length: instr_length_o};
      if (valid_o !== 1'b1) begin
        error_count++;
        if (error_count <= ReportLimit) $display("[%0d] result strobe is unknown", cycle_count);
      end else if (expected_decodes.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("[%0d] result with nothing expected: %s", cycle_count,
                   describe_decode(observed));
      end else begin
        predicted    = expected_decodes.pop_front();
        wrong_fields = "";
        if (observed.recognized !== predicted.recognized)
          wrong_fields = {wrong_fields, " recognized"};
        if (observed.form !== predicted.form) wrong_fields = {wrong_fields, " form"};
        if (observed.wide !== predicted.wide) wrong_fields = {wrong_fields, " wide"};
        if (observed.dest_is_reg !== predicted.dest_is_reg)
          wrong_fields = {wrong_fields, " dest_is_reg"};
        if (observed.reg_index !== predicted.reg_index)
          wrong_fields = {wrong_fields, " reg_index"};
        if (observed.rm_is_memory !== predicted.rm_is_memory)
          wrong_fields = {wrong_fields, " rm_is_memory"};
        if (observed.rm_code !== predicted.rm_code) wrong_fields = {wrong_fields, " rm_code"};
        if (observed.direct_address !== predicted.direct_address)
          wrong_fields = {wrong_fields, " direct_address"};
        if (observed.displacement !== predicted.displacement)
          wrong_fields = {wrong_fields, " displacement"};
        if (observed.immediate !== predicted.immediate)
          wrong_fields = {wrong_fields, " immediate"};
        if (observed.instr_length !== predicted.instr_length)
          wrong_fields = {wrong_fields, " instr_length"};
        results_checked++;
        if (wrong_fields != "") begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("[%0d] mismatch in%s", cycle_count, wrong_fields);
            $display("  expected %s", describe_decode(predicted));
            $display("  actual   %s", describe_decode(observed));
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               expected_decodes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Reset is held low from the start and is released only once.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 18;
    test_unrecognised_opcodes();
    test_rm_reg_form();
    test_immediate_forms();
    test_accumulator_forms();

    // Random traffic at a light sender gap rate, then a heavy one, then back to back.
    test_random_traffic(230, 18);
    test_random_traffic(230, 55);
    test_random_traffic(240, 0);

    start_i <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d windows sent (%0d unrecognised), %0d results checked, %0d errors.",
             windows_sent, unrecognised_tally, results_checked, error_count);
    $display("Forms decoded: rm-reg %0d, imm-rm %0d, imm-reg %0d, mem-acc %0d, acc-mem %0d.",
             form_tally[movdec_pkg::FORM_RM_REG], form_tally[movdec_pkg::FORM_IMM_RM],
             form_tally[movdec_pkg::FORM_IMM_REG], form_tally[movdec_pkg::FORM_MEM_ACC],
             form_tally[movdec_pkg::FORM_ACC_MEM]);
    if (error_count == 0 && expected_decodes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/movdec_pkg.sv
hw/rtl/movdec_decode.sv
hw/rtl/mov_instruction_decoder.sv
verif/testbench.sv
